// File: sv/drq_pkg.sv
// Shared types and constants for the descriptor ring queue.
package drq_pkg;

    // Request codes on the action field.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes on the result.
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    // Configuration register map.
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;
    localparam logic [2:0]  REG_DEPTH_ADDR = 3'd0;
    localparam int          DEPTH_REG_W    = 7;
    localparam logic [6:0]  DEPTH_RESET    = 7'd64;

    // Descriptor field width.
    localparam int FIELD_W = 32;

    // One stored descriptor.
    typedef struct packed {
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] flags;
        logic [FIELD_W-1:0] size;
    } desc_t;

    // Outcome of one request, from the ring control to the result stage.
    typedef struct packed {
        logic refused;
        logic pop_ok;
        logic has_data;
    } step_info_t;

endpackage

// File: sv/drq_cfg.sv
// APB configuration register holding the depth in use.
module drq_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drq_pkg::PADDR_W-1:0]  paddr,
    input  logic [drq_pkg::PDATA_W-1:0]  pwdata,
    output logic [drq_pkg::PDATA_W-1:0]  prdata,
    output logic [drq_pkg::DEPTH_REG_W-1:0] depth_cfg
);

    logic [drq_pkg::DEPTH_REG_W-1:0] depth_reg;
    logic                            wr_depth;

    // The port is always ready, so a write lands in its access cycle.
    assign wr_depth = psel && penable && pwrite && (paddr == drq_pkg::REG_DEPTH_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= drq_pkg::DEPTH_RESET;
        end else if (wr_depth) begin
            depth_reg <= pwdata[drq_pkg::DEPTH_REG_W-1:0];
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr == drq_pkg::REG_DEPTH_ADDR) begin
            prdata = drq_pkg::PDATA_W'(depth_reg);
        end
    end

    assign depth_cfg = depth_reg;

endmodule

// File: sv/drq_store.sv
// Descriptor memory: one write port, one read port with registered data.
module drq_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  drq_pkg::desc_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output drq_pkg::desc_t      rd_data
);

    drq_pkg::desc_t mem [DEPTH];
    drq_pkg::desc_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/drq_ring_ctrl.sv
// Ring pointers, occupancy count and the push/pop decision.
module drq_ring_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int PTR_W       = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic                              action,
    input  logic [drq_pkg::DEPTH_REG_W-1:0]   depth_cfg,
    output logic                              wr_en,
    output logic [PTR_W-1:0]                  wr_addr,
    output logic                              rd_en,
    output logic [PTR_W-1:0]                  rd_addr,
    output drq_pkg::step_info_t               info
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DEP_W = (CNT_W > drq_pkg::DEPTH_REG_W) ? CNT_W : drq_pkg::DEPTH_REG_W;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    logic [DEP_W-1:0] depth_raw;
    logic [DEP_W-1:0] depth_act;
    logic [DEP_W-1:0] wr_inc;
    logic [DEP_W-1:0] rd_inc;
    logic             full;
    logic             empty;
    logic             push_ok;
    logic             pop_ok;

    // Clamp the configured depth into 1..QUEUE_DEPTH.
    always_comb begin
        depth_raw = DEP_W'(depth_cfg);
        if (depth_raw == '0) begin
            depth_act = DEP_W'(1);
        end else if (depth_raw > DEP_W'(QUEUE_DEPTH)) begin
            depth_act = DEP_W'(QUEUE_DEPTH);
        end else begin
            depth_act = depth_raw;
        end
    end

    // Full while the count is at or above the depth in use.
    assign full  = DEP_W'(occ_reg) >= depth_act;
    assign empty = (occ_reg == '0);

    assign push_ok = step && (action == drq_pkg::ACT_PUSH) && !full;
    assign pop_ok  = step && (action == drq_pkg::ACT_POP) && !empty;

    // Pointer advance with wrap at the depth in use.
    assign wr_inc = DEP_W'(wr_ptr_reg) + DEP_W'(1);
    assign rd_inc = DEP_W'(rd_ptr_reg) + DEP_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_inc >= depth_act) ? '0 : wr_inc[PTR_W-1:0];
            occ_next    = occ_reg + CNT_W'(1);
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_inc >= depth_act) ? '0 : rd_inc[PTR_W-1:0];
            occ_next    = occ_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // Memory requests. A pop never reads the entry written in the same cycle,
    // since only one request is taken per cycle.
    assign wr_en   = push_ok;
    assign wr_addr = wr_ptr_reg;
    assign rd_en   = pop_ok;
    assign rd_addr = rd_ptr_reg;

    // Outcome as seen after this request.
    always_comb begin
        if (action == drq_pkg::ACT_PUSH) begin
            info.refused  = full;
            info.pop_ok   = 1'b0;
            info.has_data = full ? !empty : 1'b1;
        end else begin
            info.refused  = empty;
            info.pop_ok   = !empty;
            info.has_data = empty ? 1'b0 : (occ_reg != CNT_W'(1));
        end
    end

endmodule

// File: sv/descriptor_ring_queue_top.sv
// Top level of the descriptor ring queue.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    action, entry_addr, entry_flags, entry_size
//   m_        out        m_valid/m_ready    status, out_addr, out_flags, out_size, has_data
//   APB       in         psel/penable       depth_in_use at byte address 0
//
// One request is taken per cycle when the result side keeps up.
// After a request is accepted, the descriptor memory is read and the pending stage
// loads at the accepting edge; the output register and m_valid load as it moves on.
// A stalled result holds in the output register while one more request is taken
// into the pending stage; s_ready drops only when both are full.
// Reset is synchronous and active low; it clears pointers, count and the
// valid flags. The memory needs no clearing pass.
module descriptor_ring_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [drq_pkg::FIELD_W-1:0]        s_entry_addr,
    input  logic [drq_pkg::FIELD_W-1:0]        s_entry_flags,
    input  logic [drq_pkg::FIELD_W-1:0]        s_entry_size,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic [drq_pkg::FIELD_W-1:0]        m_out_addr,
    output logic [drq_pkg::FIELD_W-1:0]        m_out_flags,
    output logic [drq_pkg::FIELD_W-1:0]        m_out_size,
    output logic                               m_has_data,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drq_pkg::PADDR_W-1:0]        paddr,
    input  logic [drq_pkg::PDATA_W-1:0]        pwdata,
    output logic [drq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [drq_pkg::DEPTH_REG_W-1:0] depth_cfg;
    logic                            accept;
    logic                            out_free;
    logic                            wr_en;
    logic [PTR_W-1:0]                wr_addr;
    logic                            rd_en;
    logic [PTR_W-1:0]                rd_addr;
    drq_pkg::desc_t                  wr_data;
    drq_pkg::desc_t                  rd_data;
    drq_pkg::step_info_t             info;

    logic                            pend_valid_reg, pend_valid_next;
    drq_pkg::step_info_t             pend_info_reg;
    logic                            m_valid_reg;
    logic                            m_status_reg;
    logic                            m_has_data_reg;
    drq_pkg::desc_t                  m_desc_reg;

    assign pready = 1'b1;

    drq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .depth_cfg (depth_cfg)
    );

    // Handshake: take a request when the pending stage is empty or moves on.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !pend_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    drq_ring_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_ring_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .action    (s_action),
        .depth_cfg (depth_cfg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .info      (info)
    );

    assign wr_data.addr  = s_entry_addr;
    assign wr_data.flags = s_entry_flags;
    assign wr_data.size  = s_entry_size;

    drq_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pending stage: holds the outcome of a request while the memory read data arrives.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (pend_valid_reg && out_free) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_info_reg <= info;
        end
    end

    // Output register: descriptor only on a successful pop, zeros otherwise.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_valid_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg && out_free) begin
            m_status_reg   <= pend_info_reg.refused ? drq_pkg::STAT_REFUSED
                                                    : drq_pkg::STAT_DONE;
            m_has_data_reg <= pend_info_reg.has_data;
            m_desc_reg     <= pend_info_reg.pop_ok ? rd_data : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_has_data  = m_has_data_reg;
    assign m_out_addr  = m_desc_reg.addr;
    assign m_out_flags = m_desc_reg.flags;
    assign m_out_size  = m_desc_reg.size;

endmodule

// File: sv/drq_checker.sv
// Port-level checks for the descriptor ring queue, bound to the top level.
module drq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_status,
    input logic [drq_pkg::FIELD_W-1:0] m_out_addr,
    input logic [drq_pkg::FIELD_W-1:0] m_out_flags,
    input logic [drq_pkg::FIELD_W-1:0] m_out_size,
    input logic                        m_has_data,
    input logic                        pready
);

    // Right after reset no result is shown and a request can be taken.
    a_reset_clean: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_valid && s_ready))
        else $error("result or stall visible right after reset");

    // A refused request carries no descriptor.
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == drq_pkg::STAT_REFUSED) |->
        (m_out_addr == '0 && m_out_flags == '0 && m_out_size == '0))
        else $error("refused result carries descriptor data");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_status) && $stable(m_out_addr) && $stable(m_out_flags)
         && $stable(m_out_size) && $stable(m_has_data)))
        else $error("stalled result changed");

    // The configuration port never waits.
    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind descriptor_ring_queue_top drq_checker u_drq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_out_addr  (m_out_addr),
    .m_out_flags (m_out_flags),
    .m_out_size  (m_out_size),
    .m_has_data  (m_has_data),
    .pready      (pready)
);
